// ----- src/vtn_pkg.sv -----
// Shared types and constants for the vector transform and normalize block.
// Holds the mode codes, register indexes, register reset values and the
// control struct passed between pipeline sections. No dependencies.
`default_nettype none

package vtn_pkg;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_XFORM = 3'd2,
    MODE_NORM  = 3'd3,
    MODE_XNORM = 3'd4
  } vtn_mode_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int OFFSET_W    = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW0   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW1   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW2   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW3   = 3'd5;

  // Identity matrix at reset, using the register's fixed 16-bit layout.
  localparam logic [CFG_DATA_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
  localparam logic [CFG_DATA_W-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
  localparam logic [CFG_DATA_W-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;

  typedef struct packed {
    logic valid;
    logic sat;
  } vtn_ctl_t;

endpackage

`default_nettype wire

// ----- src/vtn_xform.sv -----
// Front section of the pipeline: input register, matrix products and offset
// add/subtract, then rounding and saturation into one result vector.
// Depends on vtn_pkg.
`default_nettype none

module vtn_xform #(
  parameter int W = 16,
  parameter int F = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [W-1:0]     in_x,
  input  logic signed [W-1:0]     in_y,
  input  logic signed [W-1:0]     in_z,
  input  logic signed [W-1:0]     in_w,
  input  logic [2:0]              mode,
  input  logic [vtn_pkg::OFFSET_W-1:0] offset_vec,
  input  logic [3:0][vtn_pkg::CFG_DATA_W-1:0] matrix,
  output vtn_pkg::vtn_ctl_t       o_ctl,
  output logic [3:0][W-1:0]       o_vec
);

  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 2;
  localparam logic ONE_CLIPS = (F >= W - 1);
  localparam logic [W-1:0] ONE_VAL = ONE_CLIPS ? {1'b0, {(W-1){1'b1}}} : W'(64'd1 << F);
  localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (F - 1));

  logic                vld1_r;
  logic signed [W-1:0] v1_r [4];

  logic                vld2_r;
  logic signed [W-1:0] v2_r [4];
  logic signed [PW-1:0] prod2_r [4][4];
  logic signed [W:0]   add2_r [3];

  logic signed [W-1:0] coef [4][4];
  logic signed [W-1:0] offs [3];

  logic signed [SW-1:0] sum [4];
  logic signed [SW-1:0] rnd [4];
  logic [3:0]           xf_ovf;
  logic [W-1:0]         xf_val [4];
  logic [2:0]           add_ovf;
  logic [W-1:0]         add_val [3];

  vtn_pkg::vtn_ctl_t    ctl_nxt;
  logic [3:0][W-1:0]    vec_nxt;

  for (genvar i = 0; i < 4; i++) begin : g_coef_row
    for (genvar j = 0; j < 4; j++) begin : g_coef_col
      assign coef[i][j] = W'(matrix[i] >> (j * W));
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_offs
    assign offs[j] = W'(offset_vec >> (j * W));
  end

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v1_r[0] <= in_x;
      v1_r[1] <= in_y;
      v1_r[2] <= in_z;
      v1_r[3] <= in_w;
    end
  end

  // Stage 2: sixteen products and the offset sums or differences.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        v2_r[i] <= v1_r[i];
        for (int j = 0; j < 4; j++) begin
          prod2_r[i][j] <= coef[i][j] * v1_r[j];
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (mode == vtn_pkg::MODE_SUB) begin
          add2_r[i] <= (W+1)'(v1_r[i]) - (W+1)'(offs[i]);
        end else begin
          add2_r[i] <= (W+1)'(v1_r[i]) + (W+1)'(offs[i]);
        end
      end
    end
  end

  // Stage 3: exact row sums, round half up, saturate.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = SW'(prod2_r[i][0]) + SW'(prod2_r[i][1]) + SW'(prod2_r[i][2])
             + SW'(prod2_r[i][3]) + HALF;
      rnd[i] = sum[i] >>> F;
      xf_ovf[i] = !((&rnd[i][SW-1:W-1]) || !(|rnd[i][SW-1:W-1]));
      if (xf_ovf[i]) begin
        xf_val[i] = rnd[i][SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        xf_val[i] = rnd[i][W-1:0];
      end
    end
    for (int i = 0; i < 3; i++) begin
      add_ovf[i] = add2_r[i][W] != add2_r[i][W-1];
      if (add_ovf[i]) begin
        add_val[i] = add2_r[i][W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        add_val[i] = add2_r[i][W-1:0];
      end
    end

    ctl_nxt.valid = vld2_r;
    case (mode)
      vtn_pkg::MODE_ADD, vtn_pkg::MODE_SUB: begin
        vec_nxt = {ONE_VAL, add_val[2], add_val[1], add_val[0]};
        ctl_nxt.sat = (|add_ovf) | ONE_CLIPS;
      end
      vtn_pkg::MODE_XFORM, vtn_pkg::MODE_XNORM: begin
        vec_nxt = {xf_val[3], xf_val[2], xf_val[1], xf_val[0]};
        ctl_nxt.sat = |xf_ovf;
      end
      default: begin
        vec_nxt = {v2_r[3], v2_r[2], v2_r[1], v2_r[0]};
        ctl_nxt.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_ctl <= '0;
    end else if (adv) begin
      o_ctl <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_vec <= vec_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/vtn_norm.sv -----
// Back section of the pipeline: squares, length sum, one stage per quotient
// bit of each scaled normalized magnitude, then sign, saturation and output.
// Depends on vtn_pkg.
`default_nettype none

module vtn_norm #(
  parameter int W = 16,
  parameter int F = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [2:0]          mode,
  input  vtn_pkg::vtn_ctl_t   i_ctl,
  input  logic [3:0][W-1:0]   i_vec,
  output logic                o_valid,
  output logic [3:0][W-1:0]   o_vec,
  output logic                o_sat,
  output logic                o_zero
);

  localparam int K   = F + 1;
  localparam int SQW = 2 * W;
  localparam int PRW = 2 * W + 2 * F + 2;
  localparam int QW  = F + 2;
  localparam int Q2W = 2 * F + 4;
  localparam int D2W = 2 * F + 6;
  localparam logic [QW-1:0] TOP = QW'(64'd1 << F);
  localparam logic [63:0] POS_LIM = (64'd1 << (W - 1)) - 64'd1;
  localparam logic [63:0] NEG_LIM = 64'd1 << (W - 1);
  localparam logic ONE_CLIPS = (F >= W - 1);
  localparam logic [W-1:0] ONE_VAL = ONE_CLIPS ? {1'b0, {(W-1){1'b1}}} : W'(64'd1 << F);

  logic [W-1:0]       mag [3];
  vtn_pkg::vtn_ctl_t  ctl4_r;
  logic [3:0][W-1:0]  vec4_r;
  logic [SQW-1:0]     sq4_r [3];

  vtn_pkg::vtn_ctl_t  ctl5_r;
  logic [3:0][W-1:0]  vec5_r;
  logic [SQW-1:0]     s5_r;
  logic [PRW-1:0]     rhs5_r [3];
  logic               zero5_r;

  vtn_pkg::vtn_ctl_t  ctlp_r [1:K];
  logic [3:0][W-1:0]  vecp_r [1:K];
  logic [SQW-1:0]     sp_r [1:K];
  logic [PRW-1:0]     rhsp_r [1:K][3];
  logic               zp_r [1:K];
  logic [QW-1:0]      q_r [1:K][3];
  logic [Q2W-1:0]     q2_r [1:K][3];

  logic [W-1:0]       qw [3];
  logic [2:0]         lane_ovf;
  logic [W-1:0]       nval [3];
  logic               is_norm;

  // Stage 4: magnitudes and squares.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = i_vec[i][W-1] ? (~i_vec[i] + W'(1)) : i_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else if (adv) begin
      ctl4_r <= i_ctl;
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec4_r <= i_vec;
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= mag[i] * mag[i];
      end
      // Stage 5: squared length and the scaled compare targets.
      vec5_r  <= vec4_r;
      s5_r    <= sq4_r[0] + sq4_r[1] + sq4_r[2];
      zero5_r <= (sq4_r[0] == '0) && (sq4_r[1] == '0) && (sq4_r[2] == '0);
      for (int i = 0; i < 3; i++) begin
        rhs5_r[i] <= {sq4_r[i], {(2*F+2){1'b0}}};
      end
    end
  end

  // One stage per quotient bit, most significant first. A candidate t is kept
  // when (2t-1)^2 * len2 <= mag^2 * 2^(2F+2), which rounds ties away from zero.
  for (genvar k = 0; k < K; k++) begin : g_bit
    localparam int B = F - k;

    vtn_pkg::vtn_ctl_t ctl_in;
    logic [3:0][W-1:0] vec_in;
    logic [SQW-1:0]    s_in;
    logic [PRW-1:0]    rhs_in [3];
    logic              z_in;
    logic [QW-1:0]     q_in [3];
    logic [Q2W-1:0]    q2_in [3];

    if (k == 0) begin : g_src0
      assign ctl_in = ctl5_r;
      assign vec_in = vec5_r;
      assign s_in   = s5_r;
      assign z_in   = zero5_r;
      for (genvar g = 0; g < 3; g++) begin : g_l
        assign rhs_in[g] = rhs5_r[g];
        assign q_in[g]   = '0;
        assign q2_in[g]  = '0;
      end
    end else begin : g_srcn
      assign ctl_in = ctlp_r[k];
      assign vec_in = vecp_r[k];
      assign s_in   = sp_r[k];
      assign z_in   = zp_r[k];
      for (genvar g = 0; g < 3; g++) begin : g_l
        assign rhs_in[g] = rhsp_r[k][g];
        assign q_in[g]   = q_r[k][g];
        assign q2_in[g]  = q2_r[k][g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctlp_r[k+1] <= '0;
      end else if (adv) begin
        ctlp_r[k+1] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        vecp_r[k+1] <= vec_in;
        sp_r[k+1]   <= s_in;
        zp_r[k+1]   <= z_in;
      end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
      logic [QW-1:0]  t;
      logic [Q2W-1:0] t2;
      logic [D2W-1:0] d2;
      logic [PRW-1:0] prod;
      logic           take;

      // t^2 is built from q^2 with shifts and adds only.
      assign t    = q_in[g] + (QW'(1) << B);
      assign t2   = q2_in[g] + (Q2W'(q_in[g]) << (B + 1)) + (Q2W'(1) << (2 * B));
      assign d2   = (D2W'(t2) << 2) - (D2W'(t) << 2) + D2W'(1);
      assign prod = PRW'(d2[2*F+1:0]) * PRW'(s_in);
      assign take = (t <= TOP) && (prod <= rhs_in[g]);

      always_ff @(posedge clk) begin
        if (adv) begin
          rhsp_r[k+1][g] <= rhs_in[g];
          q_r[k+1][g]    <= take ? t : q_in[g];
          q2_r[k+1][g]   <= take ? t2 : q2_in[g];
        end
      end
    end
  end

  // Output stage: restore signs, saturate, choose per mode.
  always_comb begin
    is_norm = (mode == vtn_pkg::MODE_NORM) || (mode == vtn_pkg::MODE_XNORM);
    for (int i = 0; i < 3; i++) begin
      qw[i] = W'(q_r[K][i]);
      if (vecp_r[K][i][W-1]) begin
        lane_ovf[i] = 64'(q_r[K][i]) > NEG_LIM;
        nval[i] = lane_ovf[i] ? {1'b1, {(W-1){1'b0}}} : (~qw[i] + W'(1));
      end else begin
        lane_ovf[i] = 64'(q_r[K][i]) > POS_LIM;
        nval[i] = lane_ovf[i] ? {1'b0, {(W-1){1'b1}}} : qw[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= ctlp_r[K].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (is_norm && !zp_r[K]) begin
        o_vec[0] <= nval[0];
        o_vec[1] <= nval[1];
        o_vec[2] <= nval[2];
        if (mode == vtn_pkg::MODE_NORM) begin
          o_vec[3] <= ONE_VAL;
          o_sat    <= ctlp_r[K].sat | (|lane_ovf) | ONE_CLIPS;
        end else begin
          o_vec[3] <= vecp_r[K][3];
          o_sat    <= ctlp_r[K].sat | (|lane_ovf);
        end
        o_zero <= 1'b0;
      end else begin
        o_vec  <= vecp_r[K];
        o_sat  <= ctlp_r[K].sat;
        o_zero <= is_norm;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/vector_transform_normalize_top.sv -----
// Top level of the vector transform and normalize block: configuration
// registers, pipeline advance control and the two pipeline sections.
// Depends on vtn_pkg, vtn_xform and vtn_norm.
//
// Usage:
//   Input channel in_valid/in_ready carries one homogeneous vector (in_x,
//   in_y, in_z, in_w) per transfer; the result channel out_valid/out_ready
//   carries (out_x, out_y, out_z, out_w, out_saturated, out_zero_length).
//   One vector can be taken every cycle while the output register is empty
//   or being taken. Between input transfer and result transfer lie three
//   front stages, two stages of squares and length, one stage per quotient
//   bit of the normalize search, and the output register.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken, so in_ready follows out_ready combinationally;
//   while the receiver stalls every stage holds its contents.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once;
//   the user must make them only while no vectors are in flight, which the block itself does not enforce.
//   Synchronous reset empties the pipeline, sets mode to add, the offset to
//   zero and the matrix to identity.
`default_nettype none

module vector_transform_normalize_top #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COMPONENT_WIDTH-1:0]    in_x,
  input  logic signed [COMPONENT_WIDTH-1:0]    in_y,
  input  logic signed [COMPONENT_WIDTH-1:0]    in_z,
  input  logic signed [COMPONENT_WIDTH-1:0]    in_w,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COMPONENT_WIDTH-1:0]    out_x,
  output logic signed [COMPONENT_WIDTH-1:0]    out_y,
  output logic signed [COMPONENT_WIDTH-1:0]    out_z,
  output logic signed [COMPONENT_WIDTH-1:0]    out_w,
  output logic                                 out_saturated,
  output logic                                 out_zero_length,
  input  logic                                 cfg_we,
  input  logic [vtn_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [vtn_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int W = COMPONENT_WIDTH;
  localparam logic ONE_CLIPS = (FRACTION_BITS >= W - 1);
  localparam logic [W-1:0] ONE_W = W'(64'd1 << FRACTION_BITS);

  logic [2:0]                          mode_r;
  logic [vtn_pkg::OFFSET_W-1:0]        offset_r;
  logic [3:0][vtn_pkg::CFG_DATA_W-1:0] matrix_r;

  logic                 adv;
  vtn_pkg::vtn_ctl_t    mid_ctl;
  logic [3:0][W-1:0]    mid_vec;
  logic [3:0][W-1:0]    res_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= vtn_pkg::MODE_ADD;
      offset_r    <= '0;
      matrix_r[0] <= vtn_pkg::ROW0_RESET;
      matrix_r[1] <= vtn_pkg::ROW1_RESET;
      matrix_r[2] <= vtn_pkg::ROW2_RESET;
      matrix_r[3] <= vtn_pkg::ROW3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vtn_pkg::REG_MODE:   mode_r      <= cfg_wdata[2:0];
        vtn_pkg::REG_OFFSET: offset_r    <= cfg_wdata[vtn_pkg::OFFSET_W-1:0];
        vtn_pkg::REG_ROW0:   matrix_r[0] <= cfg_wdata;
        vtn_pkg::REG_ROW1:   matrix_r[1] <= cfg_wdata;
        vtn_pkg::REG_ROW2:   matrix_r[2] <= cfg_wdata;
        vtn_pkg::REG_ROW3:   matrix_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  vtn_xform #(
    .W (W),
    .F (FRACTION_BITS)
  ) u_xform (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_valid),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .in_w       (in_w),
    .mode       (mode_r),
    .offset_vec (offset_r),
    .matrix     (matrix_r),
    .o_ctl      (mid_ctl),
    .o_vec      (mid_vec)
  );

  vtn_norm #(
    .W (W),
    .F (FRACTION_BITS)
  ) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .mode    (mode_r),
    .i_ctl   (mid_ctl),
    .i_vec   (mid_vec),
    .o_valid (out_valid),
    .o_vec   (res_vec),
    .o_sat   (out_saturated),
    .o_zero  (out_zero_length)
  );

  assign out_x = res_vec[0];
  assign out_y = res_vec[1];
  assign out_z = res_vec[2];
  assign out_w = res_vec[3];

`ifndef SYNTH
  a_zero_only_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      (mode_r == vtn_pkg::MODE_NORM) || (mode_r == vtn_pkg::MODE_XNORM))
    else $error("zero_length raised outside the normalize modes");

  a_undef_mode_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mode_r > 3'(vtn_pkg::MODE_XNORM)) |->
      !out_saturated && !out_zero_length)
    else $error("flag raised in a pass-through mode");

  a_norm_w_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mode_r == vtn_pkg::MODE_NORM) && !out_zero_length && !ONE_CLIPS |->
      out_w == ONE_W)
    else $error("normalized vector without w equal to one");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_vec))
    else $error("result changed while the receiver stalled");
`endif

endmodule

`default_nettype wire
